FILE: sv/topology_change_port_machine_core_macros.svh
// ----------------------------------------------------------------------------
// Topology change port machine: assertion macros
// Clocked assertion wrappers on clk; compile with ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGY_CHANGE_PORT_MACHINE_CORE_MACROS_SVH
`define TOPOLOGY_CHANGE_PORT_MACHINE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// check a property on every clock outside reset
`define TCPM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tcpm assertion failed");
// check a property on every clock, reset included
`define TCPM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("tcpm assertion failed during or after reset");
`else
`define TCPM_ASSERT(label, prop)
`define TCPM_ASSERT_RST(label, prop)
`endif

`endif

FILE: sv/tcpm_pkg.sv
// ----------------------------------------------------------------------------
// Topology change port machine: shared package
// State and code types, role codes and the request and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpm_pkg;

  // request opcodes
  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_INIT     = 1'b1;

  // port role codes
  localparam logic [2:0] ROLE_ROOT       = 3'd1;
  localparam logic [2:0] ROLE_DESIGNATED = 3'd2;
  localparam logic [2:0] ROLE_MASTER     = 3'd5;

  // stable machine states, one-hot
  typedef enum logic [2:0] {
    ST_INACTIVE = 3'b001,
    ST_LEARNING = 3'b010,
    ST_ACTIVE   = 3'b100
  } mstate_t;

  // state entered during one evaluation
  typedef enum logic [2:0] {
    EN_INACTIVE     = 3'd0,
    EN_LEARNING     = 3'd1,
    EN_DETECTED     = 3'd2,
    EN_NOTIFIED_TCN = 3'd3,
    EN_NOTIFIED_TC  = 3'd4,
    EN_PROPAGATING  = 3'd5,
    EN_ACKNOWLEDGED = 3'd6,
    EN_NONE         = 3'd7
  } entered_t;

  // one request as held in the input register
  typedef struct packed {
    logic       opcode;
    logic [2:0] port_role;
    logic       learn_on;
    logic       learning_on;
    logic       forward_on;
    logic       edge_port;
    logic       got_tcn;
    logic       got_tc_ack;
    logic       got_tc;
    logic       prop_pending;
    logic       flush_accepted;
  } req_t;

  // machine state kept between requests
  typedef struct packed {
    mstate_t machine_state;
    logic    flush_pending;
    logic    ack_to_send;
  } mach_t;

  // one result
  typedef struct packed {
    entered_t entered_state;
    logic     start_tc_timer;
    logic     zero_tc_timer;
    logic     propagate_tree;
    logic     new_info;
    logic     tc_ack_flag;
    logic     clear_tcn;
    logic     clear_tc_ack;
    logic     clear_tc;
    logic     clear_prop;
    logic     flush_request;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/tcpm_eval.sv
// ----------------------------------------------------------------------------
// Topology change port machine: evaluation logic
// Picks the transition out of the stable state, runs the entry action and
// settles the pending flush, all in one combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpm_eval (
  input  tcpm_pkg::req_t  req,
  input  tcpm_pkg::mach_t mach,
  input  logic            is_common_tree,
  output tcpm_pkg::res_t  res,
  output tcpm_pkg::mach_t mach_next
);

  logic               active_role;
  tcpm_pkg::entered_t entered;
  logic               flush_mark;

  assign active_role = req.port_role inside
    {tcpm_pkg::ROLE_ROOT, tcpm_pkg::ROLE_DESIGNATED, tcpm_pkg::ROLE_MASTER};

  // choose the transition
  always_comb begin
    entered = tcpm_pkg::EN_NONE;
    if (req.opcode == tcpm_pkg::OP_INIT) begin
      entered = tcpm_pkg::EN_INACTIVE;
    end else begin
      case (mach.machine_state)
        tcpm_pkg::ST_INACTIVE: begin
          if (req.learn_on && !mach.flush_pending) entered = tcpm_pkg::EN_LEARNING;
        end
        tcpm_pkg::ST_LEARNING: begin
          if (active_role && req.forward_on && !req.edge_port) begin
            entered = tcpm_pkg::EN_DETECTED;
          end else if ((is_common_tree && (req.got_tcn || req.got_tc_ack)) ||
                       req.got_tc || req.prop_pending) begin
            // re-enter learning so its action clears the flags
            entered = tcpm_pkg::EN_LEARNING;
          end else if (!active_role && !(req.learn_on || req.learning_on) &&
                       !(req.got_tc || req.got_tcn || req.got_tc_ack ||
                         req.prop_pending)) begin
            entered = tcpm_pkg::EN_INACTIVE;
          end
        end
        tcpm_pkg::ST_ACTIVE: begin
          if (!active_role || req.edge_port) begin
            entered = tcpm_pkg::EN_LEARNING;
          end else if (is_common_tree && req.got_tcn) begin
            entered = tcpm_pkg::EN_NOTIFIED_TCN;
          end else if (req.got_tc) begin
            entered = tcpm_pkg::EN_NOTIFIED_TC;
          end else if (req.prop_pending) begin
            entered = tcpm_pkg::EN_PROPAGATING;
          end else if (req.got_tc_ack) begin
            entered = tcpm_pkg::EN_ACKNOWLEDGED;
          end
        end
        default: begin
          entered = tcpm_pkg::EN_NONE;
        end
      endcase
    end
  end

  // run the entry action, then settle the flush mark
  always_comb begin
    res        = '0;
    mach_next  = mach;
    flush_mark = mach.flush_pending;
    case (entered)
      tcpm_pkg::EN_INACTIVE: begin
        flush_mark        = 1'b1;
        res.zero_tc_timer = 1'b1;
        if (is_common_tree) mach_next.ack_to_send = 1'b0;
        mach_next.machine_state = tcpm_pkg::ST_INACTIVE;
      end
      tcpm_pkg::EN_LEARNING: begin
        res.clear_tcn    = is_common_tree;
        res.clear_tc_ack = is_common_tree;
        res.clear_tc     = 1'b1;
        res.clear_prop   = 1'b1;
        mach_next.machine_state = tcpm_pkg::ST_LEARNING;
      end
      tcpm_pkg::EN_DETECTED: begin
        res.start_tc_timer = 1'b1;
        res.propagate_tree = 1'b1;
        res.new_info       = 1'b1;
        mach_next.machine_state = tcpm_pkg::ST_ACTIVE;
      end
      tcpm_pkg::EN_NOTIFIED_TCN, tcpm_pkg::EN_NOTIFIED_TC: begin
        res.start_tc_timer = (entered == tcpm_pkg::EN_NOTIFIED_TCN);
        res.clear_tcn      = is_common_tree;
        res.clear_tc       = 1'b1;
        res.propagate_tree = 1'b1;
        if (is_common_tree && req.port_role == tcpm_pkg::ROLE_DESIGNATED) begin
          mach_next.ack_to_send = 1'b1;
        end
        mach_next.machine_state = tcpm_pkg::ST_ACTIVE;
      end
      tcpm_pkg::EN_PROPAGATING: begin
        res.start_tc_timer = 1'b1;
        flush_mark         = 1'b1;
        res.clear_prop     = 1'b1;
        mach_next.machine_state = tcpm_pkg::ST_ACTIVE;
      end
      tcpm_pkg::EN_ACKNOWLEDGED: begin
        res.zero_tc_timer = 1'b1;
        res.clear_tc_ack  = 1'b1;
        mach_next.machine_state = tcpm_pkg::ST_ACTIVE;
      end
      default: begin
        flush_mark = mach.flush_pending;
      end
    endcase

    // drop the mark on an edge port, otherwise attempt the flush
    if (entered != tcpm_pkg::EN_NONE && flush_mark) begin
      if (req.edge_port) begin
        flush_mark = 1'b0;
      end else begin
        res.flush_request = 1'b1;
        if (req.flush_accepted) flush_mark = 1'b0;
      end
    end
    mach_next.flush_pending = flush_mark;

    res.entered_state = entered;
    res.tc_ack_flag   = mach_next.ack_to_send;
  end

endmodule

`default_nettype wire

FILE: sv/topology_change_port_machine_core.sv
// ----------------------------------------------------------------------------
// Topology change port machine core
// Per-port topology change machine of one multiple spanning tree instance.
// ----------------------------------------------------------------------------
// Each request (an init or one evaluation) is taken into an input register,
// evaluated against the held machine state in a single combinational pass
// and written with the state update into the result register. One request
// is accepted per cycle while the output side does not stall, and each gives
// exactly one result: it passes from the input register to the result
// register and leaves from there when the output side takes it. The result
// register holds while the output side stalls, and the input register keeps
// taking a new request whenever the result register frees in the same
// cycle. The is_common_tree register resets to 1 and is written through the
// configuration channel, which is always ready.
`default_nettype none

`include "topology_change_port_machine_core_macros.svh"

module topology_change_port_machine_core (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [2:0] port_role,
  input  logic       learn_on,
  input  logic       learning_on,
  input  logic       forward_on,
  input  logic       edge_port,
  input  logic       got_tcn,
  input  logic       got_tc_ack,
  input  logic       got_tc,
  input  logic       prop_pending,
  input  logic       flush_accepted,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] entered_state,
  output logic       start_tc_timer,
  output logic       zero_tc_timer,
  output logic       propagate_tree,
  output logic       new_info,
  output logic       tc_ack_flag,
  output logic       clear_tcn,
  output logic       clear_tc_ack,
  output logic       clear_tc,
  output logic       clear_prop,
  output logic       flush_request
);

  logic            is_common_tree;
  logic            req_valid;
  tcpm_pkg::req_t  req;
  tcpm_pkg::mach_t mach;
  tcpm_pkg::mach_t mach_next;
  tcpm_pkg::res_t  res_next;
  tcpm_pkg::res_t  res;
  logic            advance;
  logic            any_request;

  // move the held request into the result register when it is free
  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;
  assign cfg_ready = 1'b1;

  tcpm_eval u_eval (
    .req            (req),
    .mach           (mach),
    .is_common_tree (is_common_tree),
    .res            (res_next),
    .mach_next      (mach_next)
  );

  // control, machine state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid          <= 1'b0;
      out_valid          <= 1'b0;
      is_common_tree     <= 1'b1;
      mach.machine_state <= tcpm_pkg::ST_INACTIVE;
      mach.flush_pending <= 1'b0;
      mach.ack_to_send   <= 1'b0;
    end else begin
      if (in_ready) req_valid <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
        mach      <= mach_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) is_common_tree <= cfg_data;
    end
  end

  // capture request and result payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.opcode         <= opcode;
      req.port_role      <= port_role;
      req.learn_on       <= learn_on;
      req.learning_on    <= learning_on;
      req.forward_on     <= forward_on;
      req.edge_port      <= edge_port;
      req.got_tcn        <= got_tcn;
      req.got_tc_ack     <= got_tc_ack;
      req.got_tc         <= got_tc;
      req.prop_pending   <= prop_pending;
      req.flush_accepted <= flush_accepted;
    end
    if (advance) res <= res_next;
  end

  assign entered_state  = res.entered_state;
  assign start_tc_timer = res.start_tc_timer;
  assign zero_tc_timer  = res.zero_tc_timer;
  assign propagate_tree = res.propagate_tree;
  assign new_info       = res.new_info;
  assign tc_ack_flag    = res.tc_ack_flag;
  assign clear_tcn      = res.clear_tcn;
  assign clear_tc_ack   = res.clear_tc_ack;
  assign clear_tc       = res.clear_tc;
  assign clear_prop     = res.clear_prop;
  assign flush_request  = res.flush_request;

  // any request field raised in the current result
  assign any_request = start_tc_timer || zero_tc_timer || propagate_tree || new_info ||
                       clear_tcn || clear_tc_ack || clear_tc || clear_prop || flush_request;

  // result register empties on reset
  `TCPM_ASSERT_RST(a_reset_empty, rst |=> !out_valid)
  // an empty result register never blocks the request side
  `TCPM_ASSERT(a_no_block, !out_valid |-> in_ready)
  // a result with no transition carries no requests
  `TCPM_ASSERT(a_none_quiet, (out_valid && entered_state == tcpm_pkg::EN_NONE) |-> !any_request)
  // entering inactive always zeroes the timer
  `TCPM_ASSERT(a_inactive_zero, (out_valid && entered_state == tcpm_pkg::EN_INACTIVE) |-> zero_tc_timer)

endmodule

`default_nettype wire
